/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expected condition");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* sv/dfs_pkg.sv */
// ----------------------------------------------------------------------------
// dfs_pkg
// shared types and constants of the dmx frame buffer scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dfs_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned IDX_W   = 10;
    localparam int unsigned VAL_W   = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CHAN_W  = 10;

    localparam int unsigned BREAK_US           = 92;
    localparam int unsigned MAB_US             = 12;
    localparam int unsigned SLOT_US            = 44;
    localparam int unsigned DEADLINE_MARGIN_US = 3000;
    // break, mark after break, start code slot and margin
    localparam int unsigned FIXED_US = BREAK_US + MAB_US + SLOT_US + DEADLINE_MARGIN_US;

    localparam logic [CHAN_W-1:0] CHANNEL_COUNT_RESET = 10'd512;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_WRITE_CMP,
        ST_READ_CAP,
        ST_CLEAR_SWEEP,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic accept;
        logic init_step;
        logic exec;
        logic write_commit;
        logic capture_read;
        logic clear_step;
        logic commit_step;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic range_err;
        logic go;
        logic dirty_valid;
        logic sweep_last;
        logic commit_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* sv/dfs_ram.sv */
// ----------------------------------------------------------------------------
// dfs_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 513,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/dfs_ctrl.sv */
// ----------------------------------------------------------------------------
// dfs_ctrl
// sequencer of the frame buffer scheduler, one transaction at a time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire dfs_pkg::status_t status,
    output dfs_pkg::cmd_t         cmd
);

    import dfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                unique case (status.op)
                    OP_WRITE: state_next = status.range_err ? ST_RESULT : ST_WRITE_CMP;
                    OP_CLEAR: state_next = ST_CLEAR_SWEEP;
                    OP_TICK:  state_next = (status.go && status.dirty_valid) ?
                                           ST_COMMIT : ST_RESULT;
                    OP_READ:  state_next = ST_READ_CAP;
                    default:  state_next = ST_RESULT;
                endcase
            end
            ST_WRITE_CMP:
            begin
                cmd.write_commit = 1'b1;
                state_next       = ST_RESULT;
            end
            ST_READ_CAP:
            begin
                cmd.capture_read = 1'b1;
                state_next       = ST_RESULT;
            end
            ST_CLEAR_SWEEP:
            begin
                cmd.clear_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit_step = 1'b1;
                if (status.commit_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/dfs_datapath.sv */
// ----------------------------------------------------------------------------
// dfs_datapath
// slot stores, dirty tracking, frame timing, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dfs_datapath #(
    parameter int unsigned MAX_CHANNELS = 512
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dfs_pkg::cmd_t                 cmd,
    output dfs_pkg::status_t                   status,
    input  wire logic                          cfg_we,
    input  wire logic [dfs_pkg::CHAN_W-1:0]    cfg_data,
    input  wire logic [dfs_pkg::OP_W-1:0]      opcode,
    input  wire logic [dfs_pkg::IDX_W-1:0]     slot_index,
    input  wire logic [dfs_pkg::VAL_W-1:0]     slot_value,
    input  wire logic [dfs_pkg::TIME_W-1:0]    now_us,
    input  wire logic                          frame_done_seen,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic      [dfs_pkg::VAL_W-1:0]     read_data,
    output logic                               range_error,
    output logic                               frame_started,
    output logic                               tick_skipped,
    output logic                               timeout_resync,
    output logic      [dfs_pkg::CNT_W-1:0]     frames_sent,
    output logic      [dfs_pkg::CNT_W-1:0]     skipped_total,
    output logic      [dfs_pkg::CNT_W-1:0]     timeout_total,
    output logic      [dfs_pkg::CNT_W-1:0]     resync_total
);

    import dfs_pkg::*;

    localparam int unsigned SLOTS = MAX_CHANNELS + 1;
    localparam int unsigned AW    = $clog2(SLOTS);
    localparam int unsigned SW    = $clog2(SLOTS + 1);

    // configuration
    logic [CHAN_W-1:0] channel_count_reg;
    logic [CHAN_W-1:0] count;

    // latched transaction
    op_t               op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [VAL_W-1:0]  val_reg;
    logic [TIME_W-1:0] now_reg;
    logic              done_reg;

    // scheduling state
    logic              busy_reg;
    logic [TIME_W-1:0] deadline_reg;
    logic [CNT_W-1:0]  frames_reg;
    logic [CNT_W-1:0]  skips_reg;
    logic [CNT_W-1:0]  timeouts_reg;
    logic [CNT_W-1:0]  resyncs_reg;

    // dirty range, empty when not valid
    logic              range_valid_reg;
    logic [AW-1:0]     range_low_reg;
    logic [AW-1:0]     range_high_reg;

    // sweep address and commit write stage
    logic [SW-1:0]     addr_reg;
    logic              pipe_valid_reg;
    logic [AW-1:0]     pipe_addr_reg;

    // per-transaction result flags
    logic [VAL_W-1:0]  res_rd_reg;
    logic              res_rerr_reg;
    logic              res_started_reg;
    logic              res_skipped_reg;
    logic              res_tmo_reg;

    // result register
    logic              out_valid_reg;
    logic [VAL_W-1:0]  out_rd_reg;
    logic              out_rerr_reg;
    logic              out_started_reg;
    logic              out_skipped_reg;
    logic              out_tmo_reg;
    logic [CNT_W-1:0]  out_frames_reg;
    logic [CNT_W-1:0]  out_skips_reg;
    logic [CNT_W-1:0]  out_timeouts_reg;
    logic [CNT_W-1:0]  out_resyncs_reg;

    // memory ports
    logic              live_we;
    logic [AW-1:0]     live_waddr;
    logic [VAL_W-1:0]  live_wdata;
    logic [AW-1:0]     live_raddr;
    logic [VAL_W-1:0]  live_rdata;
    logic              tx_we;
    logic [AW-1:0]     tx_waddr;
    logic [VAL_W-1:0]  tx_wdata;
    logic [VAL_W-1:0]  tx_rdata;
    logic              dirty_we;
    logic [AW-1:0]     dirty_waddr;
    logic              dirty_wdata;
    logic              dirty_rdata;

    logic [TIME_W-1:0] late_by;
    logic              reached;
    logic              go;
    logic              range_err;
    logic              read_in_range;
    logic              changed;
    logic              issue_ok;
    logic [TIME_W-1:0] frame_len;
    logic [AW-1:0]     idx_addr;
    logic [AW-1:0]     count_addr;

    always_comb
    begin
        priority if (channel_count_reg == '0)
        begin
            count = CHAN_W'(1);
        end
        else if (channel_count_reg > CHAN_W'(MAX_CHANNELS))
        begin
            count = CHAN_W'(MAX_CHANNELS);
        end
        else
        begin
            count = channel_count_reg;
        end
    end

    assign idx_addr      = idx_reg[AW-1:0];
    assign count_addr    = count[AW-1:0];
    assign late_by       = now_reg - deadline_reg;
    assign reached       = ~late_by[TIME_W-1];
    assign go            = !busy_reg || done_reg || reached;
    assign range_err     = (idx_reg == '0) || (idx_reg > count);
    assign read_in_range = {1'b0, idx_reg} < (IDX_W + 1)'(SLOTS);
    assign changed       = live_rdata != val_reg;
    assign issue_ok      = addr_reg <= SW'(range_high_reg);
    assign frame_len     = TIME_W'(FIXED_US) + TIME_W'(count) * TIME_W'(SLOT_US);

    assign status.op          = op_reg;
    assign status.range_err   = range_err;
    assign status.go          = go;
    assign status.dirty_valid = range_valid_reg;
    assign status.sweep_last  = addr_reg == SW'(SLOTS - 1);
    assign status.commit_done = !issue_ok && !pipe_valid_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        live_we     = 1'b0;
        live_waddr  = addr_reg[AW-1:0];
        live_wdata  = '0;
        tx_we       = 1'b0;
        tx_waddr    = addr_reg[AW-1:0];
        tx_wdata    = '0;
        dirty_we    = 1'b0;
        dirty_waddr = addr_reg[AW-1:0];
        dirty_wdata = 1'b0;
        if (cmd.init_step)
        begin
            live_we  = 1'b1;
            tx_we    = 1'b1;
            dirty_we = 1'b1;
        end
        if (cmd.clear_step)
        begin
            live_we     = 1'b1;
            // slots above the channel count keep their dirty bit
            dirty_we    = addr_reg <= SW'(count_addr);
            dirty_wdata = 1'b1;
        end
        if (cmd.write_commit && changed)
        begin
            live_we     = 1'b1;
            live_waddr  = idx_addr;
            live_wdata  = val_reg;
            dirty_we    = 1'b1;
            dirty_waddr = idx_addr;
            dirty_wdata = 1'b1;
        end
        if (cmd.commit_step && pipe_valid_reg)
        begin
            dirty_we    = 1'b1;
            dirty_waddr = pipe_addr_reg;
            tx_we       = dirty_rdata;
            tx_waddr    = pipe_addr_reg;
            tx_wdata    = live_rdata;
        end
    end

    assign live_raddr = cmd.commit_step ? addr_reg[AW-1:0] : idx_addr;

    dfs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    dfs_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (tx_wdata),
        .raddr (idx_addr),
        .rdata (tx_rdata)
    );

    dfs_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_dirty_ram (
        .clk   (clk),
        .we    (dirty_we),
        .waddr (dirty_waddr),
        .wdata (dirty_wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (dirty_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= CHANNEL_COUNT_RESET;
            busy_reg          <= 1'b0;
            deadline_reg      <= '0;
            frames_reg        <= '0;
            skips_reg         <= '0;
            timeouts_reg      <= '0;
            resyncs_reg       <= '0;
            range_valid_reg   <= 1'b0;
            range_low_reg     <= '0;
            range_high_reg    <= '0;
            addr_reg          <= '0;
            pipe_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                channel_count_reg <= cfg_data;
            end

            if (cmd.init_step || cmd.clear_step)
            begin
                addr_reg <= addr_reg + SW'(1);
            end

            if (cmd.exec && op_reg == OP_CLEAR)
            begin
                addr_reg        <= '0;
                range_valid_reg <= 1'b1;
                range_low_reg   <= '0;
                range_high_reg  <= count_addr;
            end

            if (cmd.exec && op_reg == OP_TICK)
            begin
                if (busy_reg && !done_reg && reached)
                begin
                    timeouts_reg <= timeouts_reg + CNT_W'(1);
                    resyncs_reg  <= resyncs_reg + CNT_W'(1);
                end
                if (go)
                begin
                    busy_reg     <= 1'b1;
                    deadline_reg <= now_reg + frame_len;
                    frames_reg   <= frames_reg + CNT_W'(1);
                    addr_reg     <= SW'(range_low_reg);
                end
                else
                begin
                    skips_reg <= skips_reg + CNT_W'(1);
                end
            end

            if (cmd.write_commit && changed)
            begin
                range_valid_reg <= 1'b1;
                if (!range_valid_reg || idx_addr < range_low_reg)
                begin
                    range_low_reg <= idx_addr;
                end
                if (!range_valid_reg || idx_addr > range_high_reg)
                begin
                    range_high_reg <= idx_addr;
                end
            end

            // read one slot ahead of the transmit store write
            if (cmd.commit_step)
            begin
                pipe_valid_reg <= issue_ok;
                if (issue_ok)
                begin
                    addr_reg <= addr_reg + SW'(1);
                end
                if (!issue_ok && !pipe_valid_reg)
                begin
                    range_valid_reg <= 1'b0;
                end
            end
            else
            begin
                pipe_valid_reg <= 1'b0;
            end

            if (cmd.result_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg          <= op_t'(opcode);
            idx_reg         <= slot_index;
            val_reg         <= slot_value;
            now_reg         <= now_us;
            done_reg        <= frame_done_seen;
            res_rd_reg      <= '0;
            res_rerr_reg    <= 1'b0;
            res_started_reg <= 1'b0;
            res_skipped_reg <= 1'b0;
            res_tmo_reg     <= 1'b0;
        end
        if (cmd.exec && op_reg == OP_WRITE)
        begin
            res_rerr_reg <= range_err;
        end
        if (cmd.exec && op_reg == OP_TICK)
        begin
            res_started_reg <= go;
            res_skipped_reg <= !go;
            res_tmo_reg     <= busy_reg && !done_reg && reached;
        end
        if (cmd.capture_read)
        begin
            res_rd_reg <= read_in_range ? tx_rdata : '0;
        end
        if (cmd.commit_step && issue_ok)
        begin
            pipe_addr_reg <= addr_reg[AW-1:0];
        end
        if (cmd.result_load)
        begin
            out_rd_reg       <= res_rd_reg;
            out_rerr_reg     <= res_rerr_reg;
            out_started_reg  <= res_started_reg;
            out_skipped_reg  <= res_skipped_reg;
            out_tmo_reg      <= res_tmo_reg;
            out_frames_reg   <= frames_reg;
            out_skips_reg    <= skips_reg;
            out_timeouts_reg <= timeouts_reg;
            out_resyncs_reg  <= resyncs_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = out_rd_reg;
    assign range_error    = out_rerr_reg;
    assign frame_started  = out_started_reg;
    assign tick_skipped   = out_skipped_reg;
    assign timeout_resync = out_tmo_reg;
    assign frames_sent    = out_frames_reg;
    assign skipped_total  = out_skips_reg;
    assign timeout_total  = out_timeouts_reg;
    assign resync_total   = out_resyncs_reg;

endmodule

`default_nettype wire

/* sv/dmx_frame_buffer_scheduler.sv */
// ----------------------------------------------------------------------------
// dmx_frame_buffer_scheduler
// double-buffered dmx512 slot store with refresh tick frame scheduling
// ----------------------------------------------------------------------------
// One transaction is handled at a time. After acceptance, a slot read or an
// in-range channel write passes the execute, access and result states, and
// an out-of-range write or a refresh tick that commits nothing goes from
// execute straight to result. A tick that starts a frame with dirty slots
// adds a commit state, which walks the live and dirty memories one slot per
// cycle through a single read port and then drains the last write. A clear
// walks every slot in its sweep state. After reset a clearing pass over
// every slot zeroes the stores; no transaction is accepted until it ends,
// while channel_count writes are taken at any time. A finished result waits
// in the output register; the next transaction is accepted meanwhile and its
// result is held back until the previous one has been taken.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dmx_frame_buffer_scheduler #(
    parameter int unsigned MAX_CHANNELS = 512
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dfs_pkg::CHAN_W-1:0]  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [dfs_pkg::OP_W-1:0]    opcode,
    input  wire logic [dfs_pkg::IDX_W-1:0]   slot_index,
    input  wire logic [dfs_pkg::VAL_W-1:0]   slot_value,
    input  wire logic [dfs_pkg::TIME_W-1:0]  now_us,
    input  wire logic                        frame_done_seen,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic      [dfs_pkg::VAL_W-1:0]   read_data,
    output logic                             range_error,
    output logic                             frame_started,
    output logic                             tick_skipped,
    output logic                             timeout_resync,
    output logic      [dfs_pkg::CNT_W-1:0]   frames_sent,
    output logic      [dfs_pkg::CNT_W-1:0]   skipped_total,
    output logic      [dfs_pkg::CNT_W-1:0]   timeout_total,
    output logic      [dfs_pkg::CNT_W-1:0]   resync_total
);

    import dfs_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    dfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    dfs_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_valid),
        .cfg_data        (cfg_data),
        .opcode          (opcode),
        .slot_index      (slot_index),
        .slot_value      (slot_value),
        .now_us          (now_us),
        .frame_done_seen (frame_done_seen),
        .out_ready       (out_ready),
        .out_valid       (out_valid),
        .read_data       (read_data),
        .range_error     (range_error),
        .frame_started   (frame_started),
        .tick_skipped    (tick_skipped),
        .timeout_resync  (timeout_resync),
        .frames_sent     (frames_sent),
        .skipped_total   (skipped_total),
        .timeout_total   (timeout_total),
        .resync_total    (resync_total)
    );

    // a new result never overwrites one still waiting
    `ASSERT_IMPLIES(a_load_when_free, clk, rst_n, cmd.result_load, !out_valid || out_ready)
    // no transaction is taken while a memory sweep runs
    `ASSERT_IMPLIES(a_no_accept_in_sweep, clk, rst_n,
        cmd.init_step || cmd.clear_step || cmd.commit_step, !in_ready)
    // an accepted transaction blocks the input until it is done
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire
